// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// types and constants of the puct child selector
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

    localparam int ACTION_COUNT = 4096;
    localparam int VISIT_BITS   = 16;

    localparam logic [15:0] VISIT_MAX = (VISIT_BITS >= 16) ? 16'hFFFF :
        16'((33'd1 << VISIT_BITS) - 33'd1);

    localparam logic [31:0] LN2_Q32   = 32'hB17217F8;
    localparam logic [31:0] SCORE_MIN = 32'h8000_0000;
    localparam logic [31:0] SCORE_MAX = 32'h7FFF_FFFF;

    localparam logic [15:0] LOG_BASE_RESET    = 16'd19652;
    localparam logic [15:0] EXPLORATION_RESET = 16'd5120;

    // register indexes
    localparam logic CFG_LOG_BASE    = 1'b0;
    localparam logic CFG_EXPLORATION = 1'b1;

    localparam int WORK_QUEUE_DEPTH   = 2;
    localparam int RESULT_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [11:0]        child_action;
        logic [15:0]        child_prior;
        logic [15:0]        child_visits;
        logic signed [31:0] child_value_total;
        logic               child_side;
        logic [15:0]        parent_visits;
        logic               last_child;
    } child_t;

    typedef struct packed {
        logic [11:0]        best_action;
        logic signed [31:0] best_score;
    } result_t;

    typedef struct packed {
        logic [11:0] action;
        logic [15:0] prior;
        logic [15:0] visits;
        logic [31:0] value_total;
        logic        side;
        logic [15:0] parent_visits;
        logic        scored;
        logic        last;
    } work_t;

    function automatic logic [15:0] clamp_visits(input logic [15:0] v);
        return (v > VISIT_MAX) ? VISIT_MAX : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pcs_fifo.sv =====
// ----------------------------------------------------------------------------
// pcs_fifo
// small register queue between pipeline parts
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcs_front.sv =====
// ----------------------------------------------------------------------------
// pcs_front
// accepts children, clamps visit counts and marks which ones are scored
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_front (
    input  wire logic            push,
    input  wire pcs_pkg::child_t child,
    output logic                 full,
    output logic                 q_push,
    output pcs_pkg::work_t       q_data,
    input  wire logic            q_full
);

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        q_data.action        = child.child_action;
        q_data.prior         = child.child_prior;
        q_data.visits        = pcs_pkg::clamp_visits(child.child_visits);
        q_data.value_total   = child.child_value_total;
        q_data.side          = child.child_side;
        q_data.parent_visits = pcs_pkg::clamp_visits(child.parent_visits);
        q_data.scored        = (32'(child.child_action) < 32'(pcs_pkg::ACTION_COUNT));
        q_data.last          = child.last_child;
    end

endmodule

`default_nettype wire

// ===== rtl/pcs_divider.sv =====
// ----------------------------------------------------------------------------
// pcs_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [16:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [63:0]      quotient
);

    logic [63:0] dvd_reg, dvd_next;
    logic [16:0] div_reg;
    logic [16:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] rem_sh;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;
    assign rem_sh   = {rem_reg, dvd_reg[63]};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, div_reg})
            begin
                rem_next = 17'(rem_sh - {1'b0, div_reg});
                dvd_next = {dvd_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[16:0];
                dvd_next = {dvd_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start && !busy_reg)
        begin
            div_reg <= divisor;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcs_back.sv =====
// ----------------------------------------------------------------------------
// pcs_back
// scores one child at a time and tracks the running best of a node
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [15:0]    log_base,
    input  wire logic [15:0]    exploration,
    input  wire pcs_pkg::work_t q_data,
    input  wire logic           q_empty,
    output logic                q_pop,
    output logic                res_push,
    output pcs_pkg::result_t    res_data,
    input  wire logic           res_full
);

    `include "assert_macros.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RATIO  = 4'd1;
    localparam logic [3:0] S_NORM   = 4'd2;
    localparam logic [3:0] S_LOG    = 4'd3;
    localparam logic [3:0] S_LN     = 4'd4;
    localparam logic [3:0] S_PBC    = 4'd5;
    localparam logic [3:0] S_M1     = 4'd6;
    localparam logic [3:0] S_M2     = 4'd7;
    localparam logic [3:0] S_PDIV   = 4'd8;
    localparam logic [3:0] S_MDIV   = 4'd9;
    localparam logic [3:0] S_SUM    = 4'd10;
    localparam logic [3:0] S_FINISH = 4'd11;

    logic [3:0]  state_reg, state_next;
    pcs_pkg::work_t work_reg;

    // divider
    logic        div_start, div_busy, div_done;
    logic [63:0] div_dividend, div_quotient;
    logic [16:0] div_divisor;

    pcs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // datapath registers
    logic [32:0] nrm_reg;
    logic [31:0] m_reg;
    logic [4:0]  intp_reg;
    logic [15:0] frac_reg;
    logic [3:0]  log_cnt_reg;
    logic [20:0] ln_reg;
    logic [21:0] pbc_reg;
    logic [45:0] p1_reg;
    logic [29:0] pterm_reg;
    logic signed [32:0] mean_reg;
    logic        neg_reg;

    // square root
    logic [47:0] sq_rad_reg;
    logic [25:0] sq_rem_reg;
    logic [23:0] sq_root_reg;
    logic [4:0]  sq_cnt_reg;
    logic        sq_busy_reg;
    logic [25:0] sq_rem_sh, sq_trial;

    // run state
    logic [31:0] best_score_reg;
    logic [11:0] best_action_reg;
    logic        started_reg;

    logic [16:0] base;
    logic [16:0] ratio_num;
    logic [63:0] sq64;
    logic [32:0] sq_t;
    logic [52:0] ln_prod;
    logic [31:0] mag;
    logic signed [33:0] sum;
    logic [31:0] score;
    logic        take;

    assign base      = (log_base == '0) ? 17'd1 : {1'b0, log_base};
    assign ratio_num = {1'b0, work_reg.parent_visits} + base + 17'd1;
    assign sq64      = 64'(m_reg) * 64'(m_reg);
    assign sq_t      = sq64[63:31];
    assign ln_prod   = 53'({intp_reg, frac_reg}) * 53'(pcs_pkg::LN2_Q32);
    assign mag       = work_reg.value_total[31] ? 32'(~work_reg.value_total + 32'd1)
                                                : work_reg.value_total;
    assign sum       = $signed({4'b0, pterm_reg}) + $signed({mean_reg[32], mean_reg});
    assign sq_rem_sh = {sq_rem_reg[23:0], sq_rad_reg[47:46]};
    assign sq_trial  = {sq_root_reg, 2'b01};

    always_comb
    begin
        if (sum > 34'sd2147483647)
        begin
            score = pcs_pkg::SCORE_MAX;
        end
        else if (sum < -34'sd2147483648)
        begin
            score = pcs_pkg::SCORE_MIN;
        end
        else
        begin
            score = sum[31:0];
        end
    end

    assign take = !started_reg || ($signed(score) > $signed(best_score_reg));

    always_comb
    begin
        state_next   = state_reg;
        q_pop        = 1'b0;
        res_push     = 1'b0;
        div_start    = 1'b0;
        div_dividend = {31'd0, ratio_num, 16'd0};
        div_divisor  = base;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = q_data.scored ? S_RATIO : S_FINISH;
                end
            end
            S_RATIO:
            begin
                if (div_done)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (nrm_reg[32])
                begin
                    state_next = S_LOG;
                end
            end
            S_LOG:
            begin
                if (log_cnt_reg == 4'd15)
                begin
                    state_next = S_LN;
                end
            end
            S_LN:     state_next = S_PBC;
            S_PBC:    state_next = S_M1;
            S_M1:     state_next = S_M2;
            S_M2:
            begin
                div_start    = 1'b1;
                div_dividend = 64'(p1_reg * 62'(work_reg.prior));
                div_divisor  = {1'b0, work_reg.visits} + 17'd1;
                state_next   = S_PDIV;
            end
            S_PDIV:
            begin
                if (div_done)
                begin
                    if (work_reg.visits != '0)
                    begin
                        div_start    = 1'b1;
                        div_dividend = {32'd0, mag};
                        div_divisor  = {1'b0, work_reg.visits};
                        state_next   = S_MDIV;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:    state_next = S_FINISH;
            S_FINISH:
            begin
                if (!work_reg.last)
                begin
                    state_next = S_IDLE;
                end
                else if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
        if (state_reg == S_IDLE && !q_empty && q_data.scored)
        begin
            div_start    = 1'b1;
            div_dividend = {31'd0, {1'b0, q_data.parent_visits} + base + 17'd1, 16'd0};
            div_divisor  = base;
        end
    end

    assign res_data.best_action = best_action_reg;
    assign res_data.best_score  = best_score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sq_busy_reg     <= 1'b0;
            best_score_reg  <= pcs_pkg::SCORE_MIN;
            best_action_reg <= '0;
            started_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && q_data.scored)
            begin
                sq_busy_reg <= 1'b1;
            end
            else if (sq_busy_reg && sq_cnt_reg == 5'd23)
            begin
                sq_busy_reg <= 1'b0;
            end
            if (state_reg == S_SUM && take)
            begin
                best_score_reg  <= score;
                best_action_reg <= work_reg.action;
                started_reg     <= 1'b1;
            end
            if (res_push)
            begin
                best_score_reg  <= pcs_pkg::SCORE_MIN;
                best_action_reg <= '0;
                started_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg <= q_data;
            neg_reg  <= (q_data.value_total != '0) ?
                        (q_data.value_total[31] ^ !q_data.side) : !q_data.side;
            sq_rad_reg  <= {q_data.parent_visits, 32'd0};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= '0;
        end
        else if (sq_busy_reg)
        begin
            if (sq_rem_sh >= sq_trial)
            begin
                sq_rem_reg  <= sq_rem_sh - sq_trial;
                sq_root_reg <= {sq_root_reg[22:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_rem_sh;
                sq_root_reg <= {sq_root_reg[22:0], 1'b0};
            end
            sq_rad_reg <= {sq_rad_reg[45:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
        case (state_reg)
            S_RATIO:
            begin
                nrm_reg     <= div_quotient[32:0];
                intp_reg    <= 5'd16;
                frac_reg    <= '0;
                log_cnt_reg <= '0;
            end
            S_NORM:
            begin
                if (nrm_reg[32])
                begin
                    m_reg <= nrm_reg[32:1];
                end
                else
                begin
                    nrm_reg  <= {nrm_reg[31:0], 1'b0};
                    intp_reg <= intp_reg - 1'b1;
                end
            end
            S_LOG:
            begin
                if (sq_t[32])
                begin
                    m_reg    <= sq_t[32:1];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_reg    <= sq_t[31:0];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
                log_cnt_reg <= log_cnt_reg + 1'b1;
            end
            S_LN:  ln_reg  <= ln_prod[52:32];
            S_PBC: pbc_reg <= 22'(ln_reg) + 22'({exploration, 4'b0000});
            S_M1:  p1_reg  <= 46'(pbc_reg) * 46'(sq_root_reg);
            S_PDIV:
            begin
                pterm_reg <= div_quotient[61:32];
                mean_reg  <= '0;
            end
            S_MDIV:
            begin
                mean_reg <= neg_reg ? -$signed({1'b0, div_quotient[31:0]})
                                    : $signed({1'b0, div_quotient[31:0]});
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_IMPLIES(a_push_on_last, clk, rst_n, res_push,
        (state_reg == S_FINISH) && work_reg.last)
    `ASSERT_IMPLIES(a_div_idle_on_start, clk, rst_n, div_start, !div_busy)
    `ASSERT_NEXT(a_run_cleared, clk, rst_n, res_push, !started_reg)
    `ASSERT_IMPLIES(a_sqrt_ready, clk, rst_n, state_reg == S_M1, !sq_busy_reg)

endmodule

`default_nettype wire

// ===== rtl/puct_child_select.sv =====
// ----------------------------------------------------------------------------
// puct_child_select
// picks the child with the highest puct score among a node's children
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  child     push / full      child_t, one child per transaction
//  result    pop / empty      result_t, one per node on its last child
//  config    cfg_write        cfg_index, cfg_data
//
//  in the back end a scored child runs three 64-step divisions on the shared
//  serial divider plus 1 to 17 normalize and 16 log steps
//  an unvisited child skips the mean division
//  an unscored child goes from idle straight to the finish state
//  a two-entry queue on each side lets input and output stall independently
//  reset clears the run state and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module puct_child_select (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pcs_pkg::child_t  child,
    output logic                  full,
    input  wire logic             pop,
    output pcs_pkg::result_t      result,
    output logic                  empty,
    input  wire logic             cfg_write,
    input  wire logic             cfg_index,
    input  wire logic [15:0]      cfg_data
);

    logic [15:0] log_base_reg, exploration_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_base_reg    <= pcs_pkg::LOG_BASE_RESET;
            exploration_reg <= pcs_pkg::EXPLORATION_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pcs_pkg::CFG_LOG_BASE:    log_base_reg    <= cfg_data;
                pcs_pkg::CFG_EXPLORATION: exploration_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    logic             fq_push, fq_full, fq_pop, fq_empty;
    pcs_pkg::work_t   fq_wdata, fq_rdata;
    logic             rq_push, rq_full;
    pcs_pkg::result_t rq_wdata;

    pcs_front u_front (
        .push   (push),
        .child  (child),
        .full   (full),
        .q_push (fq_push),
        .q_data (fq_wdata),
        .q_full (fq_full)
    );

    pcs_fifo #(
        .WIDTH ($bits(pcs_pkg::work_t)),
        .DEPTH (pcs_pkg::WORK_QUEUE_DEPTH)
    ) u_work_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_wdata),
        .full  (fq_full),
        .pop   (fq_pop),
        .rdata (fq_rdata),
        .empty (fq_empty)
    );

    pcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .log_base    (log_base_reg),
        .exploration (exploration_reg),
        .q_data      (fq_rdata),
        .q_empty     (fq_empty),
        .q_pop       (fq_pop),
        .res_push    (rq_push),
        .res_data    (rq_wdata),
        .res_full    (rq_full)
    );

    pcs_fifo #(
        .WIDTH ($bits(pcs_pkg::result_t)),
        .DEPTH (pcs_pkg::RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (rq_wdata),
        .full  (rq_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

// ===== verif/puct_child_select_tb.sv =====
// ----------------------------------------------------------------------------
// puct_child_select_tb
// self-checking bench for the puct child selector
// ----------------------------------------------------------------------------
// node children are pushed through the queue-style input and best-child
// results are popped from the output. A bit-exact score model predicts each
// result. The bench walks a directed table, then random nodes under several
// register settings, with random idling and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module puct_child_select_tb;

    localparam int IDLE_LIMIT = 10000;
    localparam int DRAIN_WAIT = 300;
    localparam int HOLD_CYCLES = 2000;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct {
        pcs_pkg::child_t  c;
        bit               typed;
        pcs_pkg::result_t want;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    push;
    pcs_pkg::child_t  child;
    logic    full;
    logic    pop;
    pcs_pkg::result_t result;
    logic    empty;
    logic    cfg_write;
    logic    cfg_index;
    logic [15:0] cfg_data;

    logic [15:0] base_reg;
    logic [15:0] explore_reg;
    logic signed [31:0] best_score_so_far;
    logic [11:0] best_action_so_far;
    bit          node_open;

    pcs_pkg::result_t pending_best[$];
    int      errors;
    int      results_seen;
    int      children_sent;
    int      reg_writes;
    bit      no_idle;
    int      hold_requests;

    puct_child_select u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .child     (child),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        int k;
        logic [63:0] m;
        logic [63:0] frac;
        if (x < 64'd65536)
            return 64'd0;
        k = 63;
        frac = 64'd0;
        while (k > 0 && x[k] == 1'b0)
            k--;
        m = (k <= 31) ? (x << (31 - k)) : (x >> (k - 31));
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(k - 16) << 16) | frac;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 64'd0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] child_score(input pcs_pkg::child_t c);
        logic [63:0] b;
        logic [63:0] pv;
        logic [63:0] cv;
        logic [63:0] ratio;
        logic [63:0] ln_val;
        logic [63:0] pbc;
        logic [63:0] sq;
        logic [63:0] prod;
        logic [63:0] pterm;
        logic [31:0] v;
        logic [31:0] v_abs;
        logic [63:0] mag;
        bit          neg;
        longint      mean;
        longint      sum;
        b = (base_reg == 16'd0) ? 64'd1 : 64'(base_reg);
        pv = 64'(c.parent_visits);
        cv = 64'(c.child_visits);
        ratio = ((pv + b + 64'd1) << 16) / b;
        ln_val = (log2_fixed(ratio) * 64'(pcs_pkg::LN2_Q32)) >> 32;
        pbc = ln_val + (64'(explore_reg) << 4);
        sq = root_floor(pv << 32);
        prod = pbc * sq * 64'(c.child_prior);
        pterm = (prod / (cv + 64'd1)) >> 32;
        mean = 0;
        if (cv != 64'd0)
        begin
            v = c.child_value_total;
            neg = v[31];
            v_abs = neg ? (~v + 32'd1) : v;
            mag = 64'(v_abs);
            if (mag == 64'd0)
                neg = 1'b0;
            if (!c.child_side)
                neg = !neg;
            mean = neg ? -longint'(mag / cv) : longint'(mag / cv);
        end
        sum = longint'(pterm) + mean;
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    // update the running best and return whether the node closed
    function automatic bit track_child(input pcs_pkg::child_t c, output pcs_pkg::result_t r);
        logic signed [31:0] s;
        if (int'(c.child_action) < pcs_pkg::ACTION_COUNT)
        begin
            s = child_score(c);
            if (!node_open || s > best_score_so_far)
            begin
                best_score_so_far = s;
                best_action_so_far = c.child_action;
                node_open = 1'b1;
            end
        end
        r.best_action = best_action_so_far;
        r.best_score = best_score_so_far;
        if (!c.last_child)
            return 1'b0;
        best_score_so_far = pcs_pkg::SCORE_MIN;
        best_action_so_far = '0;
        node_open = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_child(input pcs_pkg::child_t c, input bit typed,
                              input pcs_pkg::result_t want);
        pcs_pkg::result_t r;
        int gap;
        gap = (!no_idle && $urandom_range(99) < 8) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        child <= c;
        do
            @(posedge clk);
        while (full);
        children_sent++;
        if (track_child(c, r))
            pending_best.insert(pending_best.size(), typed ? want : r);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_best.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == pcs_pkg::CFG_LOG_BASE)
            base_reg = data;
        else
            explore_reg = data;
        reg_writes++;
    endtask

    function automatic pcs_pkg::child_t random_child(input bit last);
        pcs_pkg::child_t c;
        c.child_action = 12'($urandom_range(4095));
        c.child_prior = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0)
                                                 : 16'($urandom);
        c.child_visits = $urandom_range(1) ? 16'($urandom_range(20)) : 16'($urandom);
        c.child_value_total = $urandom;
        c.child_side = 1'($urandom_range(1));
        c.parent_visits = $urandom_range(1) ? 16'($urandom_range(400)) : 16'($urandom);
        c.last_child = last;
        return c;
    endfunction

    // result side: random pop with requested long holds
    initial
    begin : result_side
        int holds_seen;
        int hold_left;
        holds_seen = 0;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_best.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    errors++;
                end
                else
                begin
                    pcs_pkg::result_t w;
                    w = pending_best.pop_front();
                    results_seen++;
                    if (result.best_action !== w.best_action)
                    begin
                        $error("best_action expected %0d actual %0d",
                               w.best_action, result.best_action);
                        errors++;
                    end
                    if (result.best_score !== w.best_score)
                    begin
                        $error("best_score expected %0d actual %0d",
                               w.best_score, result.best_score);
                        errors++;
                    end
                end
            end
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t rows[$];
        stim_row_t row;
        int remaining;
        int per_phase;
        pcs_pkg::child_t c;
        pcs_pkg::result_t none;

        errors = 0;
        results_seen = 0;
        children_sent = 0;
        reg_writes = 0;
        no_idle = 1'b0;
        hold_requests = 0;
        push = 1'b0;
        child = '0;
        cfg_write = 1'b0;
        cfg_index = pcs_pkg::CFG_LOG_BASE;
        cfg_data = '0;
        base_reg = pcs_pkg::LOG_BASE_RESET;
        explore_reg = pcs_pkg::EXPLORATION_RESET;
        best_score_so_far = pcs_pkg::SCORE_MIN;
        best_action_so_far = '0;
        node_open = 1'b0;
        none = '0;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero prior and zero visits everywhere: score is zero
        row.c = '{12'd5, 16'h0, 16'd0, 32'sd0, 1'b1, 16'd0, 1'b1};
        row.typed = 1'b1;
        row.want = '{12'd5, 32'sd0};
        rows.insert(rows.size(), row);
        // most negative value kept as is
        row.c = '{12'd4095, 16'h0, 16'd1, 32'h8000_0000, 1'b1, 16'd0, 1'b1};
        row.want = '{12'd4095, pcs_pkg::SCORE_MIN};
        rows.insert(rows.size(), row);
        // most negative value negated saturates high
        row.c = '{12'd0, 16'h0, 16'd1, 32'h8000_0000, 1'b0, 16'd0, 1'b1};
        row.want = '{12'd0, pcs_pkg::SCORE_MAX};
        rows.insert(rows.size(), row);
        row.typed = 1'b0;
        row.want = none;
        // tie, earlier child wins
        row.c = '{12'd7, 16'h4000, 16'd3, 32'sd65536, 1'b1, 16'd50, 1'b0};
        rows.insert(rows.size(), row);
        row.c = '{12'd9, 16'h4000, 16'd3, 32'sd65536, 1'b1, 16'd50, 1'b1};
        rows.insert(rows.size(), row);
        // field extremes
        row.c = '{12'hFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b0, 16'hFFFF, 1'b0};
        rows.insert(rows.size(), row);
        row.c = '{12'h800, 16'hFFFF, 16'd0, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, 1'b1};
        rows.insert(rows.size(), row);
        row.c = '{12'd33, 16'h1234, 16'd3, 32'sd0, 1'b0, 16'd100, 1'b1};
        rows.insert(rows.size(), row);
        // later child beats a bad first one
        row.c = '{12'd100, 16'h0100, 16'd4, -32'sd400000, 1'b1, 16'd9, 1'b0};
        rows.insert(rows.size(), row);
        row.c = '{12'd200, 16'h8000, 16'd1, 32'sd10000, 1'b1, 16'd9, 1'b0};
        rows.insert(rows.size(), row);
        row.c = '{12'd300, 16'h0001, 16'd2, -32'sd5, 1'b0, 16'd9, 1'b1};
        rows.insert(rows.size(), row);

        foreach (rows[i])
            send_child(rows[i].c, rows[i].typed, rows[i].want);

        // receiver holds off while the sender keeps offering single-child nodes
        hold_requests++;
        for (int i = 0; i < 20; i++)
            send_child(random_child(1'b1), 1'b0, none);

        per_phase = RANDOM_ITEMS / 4;
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    write_reg(pcs_pkg::CFG_LOG_BASE, 16'd1);
                    write_reg(pcs_pkg::CFG_EXPLORATION, 16'd0);
                end
                1:
                begin
                    write_reg(pcs_pkg::CFG_LOG_BASE, 16'hFFFF);
                    write_reg(pcs_pkg::CFG_EXPLORATION, 16'hFFFF);
                end
                2:
                begin
                    write_reg(pcs_pkg::CFG_LOG_BASE, 16'd0);
                    write_reg(pcs_pkg::CFG_EXPLORATION, 16'($urandom));
                end
                default:
                begin
                    write_reg(pcs_pkg::CFG_LOG_BASE, 16'($urandom_range(1, 65535)));
                    write_reg(pcs_pkg::CFG_EXPLORATION, 16'($urandom));
                end
            endcase
            remaining = per_phase;
            while (remaining > 0)
            begin
                no_idle = (phase == 1) && (remaining < 200);
                c = random_child(remaining == 1 || $urandom_range(4) == 0);
                send_child(c, 1'b0, none);
                remaining--;
            end
        end

        drain_results();
        $display("covered %0d children and %0d node results over %0d register writes",
                 children_sent, results_seen, reg_writes);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
